>>> sv/jsfe_pkg.sv
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types, codes and helper functions of the JSON string field extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

  // Input beat: one UTF-16 code unit of the text
  typedef struct packed {
    logic [15:0] text_unit;
    logic        end_of_text;
  } in_beat_t;

  // Output beat: one decoded unit or one terminal status
  typedef struct packed {
    logic [15:0] value_unit;
    logic [2:0]  status;
    logic        last;
  } out_beat_t;

  // Status codes
  localparam logic [2:0] ST_UNIT        = 3'd0;
  localparam logic [2:0] ST_DONE        = 3'd1;
  localparam logic [2:0] ST_KEY_MISSING = 3'd2;
  localparam logic [2:0] ST_NOT_STRING  = 3'd3;
  localparam logic [2:0] ST_BAD_ESCAPE  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED   = 3'd5;

  // Characters
  localparam logic [15:0] CH_QUOTE     = 16'h0022;
  localparam logic [15:0] CH_BACKSLASH = 16'h005C;
  localparam logic [15:0] CH_SLASH     = 16'h002F;
  localparam logic [15:0] CH_COLON     = 16'h003A;
  localparam logic [15:0] CH_B         = 16'h0062;
  localparam logic [15:0] CH_F         = 16'h0066;
  localparam logic [15:0] CH_N         = 16'h006E;
  localparam logic [15:0] CH_R         = 16'h0072;
  localparam logic [15:0] CH_T         = 16'h0074;
  localparam logic [15:0] CH_U         = 16'h0075;

  // Key token "path", quotes included
  localparam int TOKEN_LEN = 6;
  localparam logic [15:0] KEY_TOKEN [TOKEN_LEN] = '{
    16'h0022, 16'h0070, 16'h0061, 16'h0074, 16'h0068, 16'h0022
  };

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Parser phase, one-hot
  typedef enum logic [6:0] {
    PH_SEARCH   = 7'b0000001,
    PH_AFTERKEY = 7'b0000010,
    PH_AFTERCOL = 7'b0000100,
    PH_STRING   = 7'b0001000,
    PH_ESCAPE   = 7'b0010000,
    PH_HEX      = 7'b0100000,
    PH_FINISHED = 7'b1000000
  } phase_t;

  // Results of one step, packed so the first valid result is in first
  typedef struct packed {
    logic [1:0] count;
    out_beat_t  first;
    out_beat_t  second;
  } step_out_t;

  function automatic logic is_space(input logic [15:0] c);
    return ((c >= 16'h0009) && (c <= 16'h000D)) || (c == 16'h0020);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if ((c >= 16'h0030) && (c <= 16'h0039)) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= 16'h0061) && (c <= 16'h0066)) ||
                 ((c >= 16'h0041) && (c <= 16'h0046))) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic out_beat_t make_result(input logic [15:0] unit,
                                            input logic [2:0]  st);
    out_beat_t r;
    r.value_unit = unit;
    r.status     = st;
    r.last       = (st != ST_UNIT);
    return r;
  endfunction

endpackage

>>> sv/jsfe_step.sv
// ----------------------------------------------------------------------------
// jsfe_step
// Parser state and the one-step update; yields up to two results per unit.
// ----------------------------------------------------------------------------
module jsfe_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  jsfe_pkg::in_beat_t item,
  output jsfe_pkg::step_out_t res
);
  import jsfe_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  match_position, match_position_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_accumulator, hex_accumulator_next;

  logic [15:0] c;
  logic [2:0]  mp_idx;
  logic [2:0]  mp_inc;
  logic [4:0]  hd;
  logic [15:0] acc_shift;
  logic        r0_valid;
  out_beat_t   r0;
  logic        r1_valid;
  out_beat_t   r1;

  assign c         = item.text_unit;
  assign mp_idx    = (match_position >= 3'(TOKEN_LEN)) ? 3'd0 : match_position;
  assign mp_inc    = mp_idx + 3'd1;
  assign hd        = hex_digit(c);
  assign acc_shift = {hex_accumulator[11:0], hd[3:0]};

  always_comb begin
    phase_next           = phase;
    match_position_next  = match_position;
    hex_count_next       = hex_count;
    hex_accumulator_next = hex_accumulator;
    r0_valid             = 1'b0;
    r0                   = make_result(16'd0, ST_UNIT);
    r1_valid             = 1'b0;
    r1                   = make_result(16'd0, ST_UNIT);

    unique case (phase)
      PH_SEARCH: begin
        if (c == KEY_TOKEN[mp_idx]) begin
          if (mp_inc == 3'(TOKEN_LEN)) begin
            match_position_next = 3'd0;
            phase_next          = PH_AFTERKEY;
          end else begin
            match_position_next = mp_inc;
          end
        end else begin
          match_position_next = (c == CH_QUOTE) ? 3'd1 : 3'd0;
        end
      end
      PH_AFTERKEY: begin
        if (is_space(c)) begin
          phase_next = PH_AFTERKEY;
        end else if (c == CH_COLON) begin
          phase_next = PH_AFTERCOL;
        end else begin
          // resume the search at this unit; only a quote can start a token
          phase_next          = PH_SEARCH;
          match_position_next = (c == CH_QUOTE) ? 3'd1 : 3'd0;
        end
      end
      PH_AFTERCOL: begin
        if (is_space(c)) begin
          phase_next = PH_AFTERCOL;
        end else if (c == CH_QUOTE) begin
          phase_next = PH_STRING;
        end else begin
          r0_valid   = 1'b1;
          r0         = make_result(16'd0, ST_NOT_STRING);
          phase_next = PH_FINISHED;
        end
      end
      PH_STRING: begin
        if (c == CH_QUOTE) begin
          r0_valid   = 1'b1;
          r0         = make_result(16'd0, ST_DONE);
          phase_next = PH_FINISHED;
        end else if (c == CH_BACKSLASH) begin
          phase_next = PH_ESCAPE;
        end else begin
          r0_valid = 1'b1;
          r0       = make_result(c, ST_UNIT);
        end
      end
      PH_ESCAPE: begin
        phase_next = PH_STRING;
        r0_valid   = 1'b1;
        if (c == CH_QUOTE || c == CH_BACKSLASH || c == CH_SLASH) begin
          r0 = make_result(c, ST_UNIT);
        end else if (c == CH_B) begin
          r0 = make_result(16'h0008, ST_UNIT);
        end else if (c == CH_F) begin
          r0 = make_result(16'h000C, ST_UNIT);
        end else if (c == CH_N) begin
          r0 = make_result(16'h000A, ST_UNIT);
        end else if (c == CH_R) begin
          r0 = make_result(16'h000D, ST_UNIT);
        end else if (c == CH_T) begin
          r0 = make_result(16'h0009, ST_UNIT);
        end else if (c == CH_U) begin
          r0_valid             = 1'b0;
          hex_count_next       = 2'd0;
          hex_accumulator_next = 16'd0;
          phase_next           = PH_HEX;
        end else begin
          r0         = make_result(16'd0, ST_BAD_ESCAPE);
          phase_next = PH_FINISHED;
        end
      end
      PH_HEX: begin
        if (!hd[4]) begin
          r0_valid   = 1'b1;
          r0         = make_result(16'd0, ST_BAD_ESCAPE);
          phase_next = PH_FINISHED;
        end else if (hex_count == 2'd3) begin
          r0_valid             = 1'b1;
          r0                   = make_result(acc_shift, ST_UNIT);
          hex_count_next       = 2'd0;
          hex_accumulator_next = 16'd0;
          phase_next           = PH_STRING;
        end else begin
          hex_accumulator_next = acc_shift;
          hex_count_next       = hex_count + 2'd1;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // end of text: terminal status from where the step left off, then reset
    if (item.end_of_text) begin
      if (phase_next == PH_SEARCH || phase_next == PH_AFTERKEY) begin
        r1_valid = 1'b1;
        r1       = make_result(16'd0, ST_KEY_MISSING);
      end else if (phase_next != PH_FINISHED) begin
        r1_valid = 1'b1;
        r1       = make_result(16'd0, ST_TRUNCATED);
      end
      phase_next           = PH_SEARCH;
      match_position_next  = 3'd0;
      hex_count_next       = 2'd0;
      hex_accumulator_next = 16'd0;
    end
  end

  always_comb begin
    res.count  = {1'b0, r0_valid} + {1'b0, r1_valid};
    res.first  = r0_valid ? r0 : r1;
    res.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SEARCH;
      match_position  <= 3'd0;
      hex_count       <= 2'd0;
      hex_accumulator <= 16'd0;
    end else if (fire) begin
      phase           <= phase_next;
      match_position  <= match_position_next;
      hex_count       <= hex_count_next;
      hex_accumulator <= hex_accumulator_next;
    end
  end

endmodule

>>> sv/jsfe_outq.sv
// ----------------------------------------------------------------------------
// jsfe_outq
// Small result queue; takes up to two beats per cycle, gives one.
// ----------------------------------------------------------------------------
module jsfe_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  jsfe_pkg::step_out_t  push,
  output logic                 room2,
  output logic                 result_valid,
  input  logic                 result_ready,
  output jsfe_pkg::out_beat_t  result
);
  import jsfe_pkg::*;

  out_beat_t          slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               pop;
  logic [QPTR_W-1:0]  wr_ptr_1;

  assign result_valid = (count != '0);
  assign result       = slots[rd_ptr];
  assign pop          = result_valid && result_ready;
  assign room2        = (count <= QCNT_W'(QDEPTH - 2));
  assign wr_ptr_1     = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

endmodule

>>> sv/json_string_field_extractor.sv
// ----------------------------------------------------------------------------
// json_string_field_extractor
// Streams UTF-16 text, finds "path": "..." and emits the decoded string value
// followed by one terminal status beat per text.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  text    | text_valid / text_ready    | text.text_unit, text.end_of_text
//  result  | result_valid/result_ready  | result.value_unit, .status, .last
//
//  One text beat per cycle sustained while the queue has room for two beats.
//  A beat waits in the input register until the step fires; its results
//  (zero, one or two) land in a 4-entry queue, whose head shows on the
//  result port. The step fires only while the queue has room for two beats,
//  so a stalled result side backs up into text_ready within a few beats.
//  Synchronous reset empties both stages and returns the parser to the search.
// ----------------------------------------------------------------------------
module json_string_field_extractor (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_ready,
  input  jsfe_pkg::in_beat_t  text,
  output logic                result_valid,
  input  logic                result_ready,
  output jsfe_pkg::out_beat_t result
);
  import jsfe_pkg::*;

  // input register
  logic      hold_valid;
  in_beat_t  hold;

  // step/queue coupling
  logic      room2;
  logic      fire;
  step_out_t step_res;
  step_out_t push;

  // step the held beat only when the queue can absorb its worst case
  assign fire       = hold_valid && room2;
  assign text_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (text_valid && text_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      hold <= text;
    end
  end

  jsfe_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (hold),
    .res  (step_res)
  );

  // nothing enters the queue unless the step actually fires
  always_comb begin
    push       = step_res;
    push.count = fire ? step_res.count : 2'd0;
  end

  jsfe_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room2        (room2),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> sv/jsfe_checker.sv
// ----------------------------------------------------------------------------
// jsfe_checker
// Port-level checks of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module jsfe_checker (
  input logic                clk,
  input logic                rst,
  input logic                text_valid,
  input logic                text_ready,
  input jsfe_pkg::in_beat_t  text,
  input logic                result_valid,
  input logic                result_ready,
  input jsfe_pkg::out_beat_t result
);
  import jsfe_pkg::*;

  // a held result beat must not change
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // a waiting text beat stays put until taken
  a_text_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid && $stable(text))
    else $error("text beat changed while stalled");

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && text_ready)
    else $error("block not empty right after reset");

  // last marks exactly the status beats
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last == (result.status != ST_UNIT)))
    else $error("last does not match status");

  // status beats carry no unit and use only defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |->
      (result.value_unit == 16'd0) &&
      (result.status == ST_DONE || result.status == ST_KEY_MISSING ||
       result.status == ST_NOT_STRING || result.status == ST_BAD_ESCAPE ||
       result.status == ST_TRUNCATED))
    else $error("malformed status beat");

endmodule

bind json_string_field_extractor jsfe_checker u_jsfe_checker (
  .clk          (clk),
  .rst          (rst),
  .text_valid   (text_valid),
  .text_ready   (text_ready),
  .text         (text),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
